// ===== src/anxb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// anxb_pkg
// Shared types and constants for the Annex B NAL unit extractor.
// ----------------------------------------------------------------------------
package anxb_pkg;

    // Byte values that the start code and emulation prevention rules look for.
    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE  = 8'h01;
    localparam logic [7:0] BYTE_EPB  = 8'h03;

    // One input byte yields at most this many output beats.
    localparam int MAX_RESULTS = 4;
    localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    // Zero-run counters saturate here.
    localparam logic [1:0] ZERO_RUN_MAX = 2'd2;
    localparam logic [1:0] HELD_MAX     = 2'd3;

    typedef struct packed {
        logic [7:0] payload;
        logic       has_byte;
        logic       unit_first;
        logic       long_start;
        logic       unit_end;
    } t_result;

endpackage
`default_nettype wire

// ===== src/annexb_nal_unit_extractor.sv =====
`default_nettype none
// Result beats of a byte are loaded into the result buffer when the byte is accepted.
// Throughput: one byte per cycle while each byte yields at most one result beat and the
// receiver is ready. A byte that yields k beats (k up to 4: flushed held zeros plus the
// byte) keeps s_tready low while the buffer drains, one beat per cycle when ready.
// Reset (synchronous, active low) clears the parser state and the result buffer and
// sets the emulation prevention removal enable to 1.
// ----------------------------------------------------------------------------
// annexb_nal_unit_extractor
// Splits an H.264 Annex B byte stream into NAL unit payload beats, dropping
// start codes and, when enabled, emulation prevention bytes.
// ----------------------------------------------------------------------------
module annexb_nal_unit_extractor
    import anxb_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Configuration: emulation prevention removal enable.
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_wdata,
    // Input byte stream.
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,    // [7:0] stream_byte
    input  wire logic       s_tlast,    // stream_end
    // Output payload stream.
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,    // [7:0] payload_byte
    output logic [2:0]      m_tuser,    // [0] has_byte, [1] unit_first, [2] long_start_code
    output logic            m_tlast     // unit_end
);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic                 r_epb_en;
    logic                 r_in_unit;
    logic [1:0]           r_held;       // zeros held back as a possible start code
    logic [1:0]           r_zero_run;   // consecutive zero payload bytes, saturating
    logic                 r_first;      // next beat of the open unit is its first
    logic                 r_long;       // open unit began with a 4-byte start code
    logic [RES_CNT_W-1:0] r_cnt;        // beats loaded in the result buffer
    logic [RES_CNT_W-1:0] r_idx;        // next beat to send
    t_result              r_res [MAX_RESULTS];

    logic                 n_in_unit;
    logic [1:0]           n_held;
    logic [1:0]           n_zero_run;
    logic                 n_first;
    logic                 n_long;
    logic [RES_CNT_W-1:0] n_cnt;
    t_result              n_res [MAX_RESULTS];

    logic                 w_accept;
    logic                 w_drain_last;

    // ------------------------------------------------------------------
    // Handshake. The result buffer accepts a new byte when it is empty or
    // its last beat leaves in this cycle.
    // ------------------------------------------------------------------
    assign m_tvalid     = (r_idx != r_cnt);
    assign w_drain_last = ((r_idx + RES_CNT_W'(1)) == r_cnt) && m_tready;
    assign s_tready     = (r_idx == r_cnt) || w_drain_last;
    assign w_accept     = s_tvalid && s_tready;

    assign m_tdata = r_res[r_idx[RES_IDX_W-1:0]].payload;
    assign m_tuser = {r_res[r_idx[RES_IDX_W-1:0]].long_start,
                      r_res[r_idx[RES_IDX_W-1:0]].unit_first,
                      r_res[r_idx[RES_IDX_W-1:0]].has_byte};
    assign m_tlast = r_res[r_idx[RES_IDX_W-1:0]].unit_end;

    // ------------------------------------------------------------------
    // Parser. Every byte falls into one of three cases:
    //  - a zero: held back while fewer than three are held; beyond that the
    //    oldest held zero becomes payload,
    //  - a one after at least two held zeros: a start code,
    //  - anything else: held zeros are flushed as payload, then the byte.
    // Only the trailing byte can be an emulation prevention byte, so the
    // beats of a step are always some zeros followed by at most one byte.
    // End of stream flushes held zeros into the open unit and closes it.
    // ------------------------------------------------------------------
    always_comb begin
        logic       v_is_zero;
        logic       v_is_start;
        logic [2:0] v_z;         // zero beats in this step
        logic       v_tail;      // trailing input byte is sent
        logic [2:0] v_run_sum;
        logic [2:0] v_n;
        logic       v_slot_first;

        v_is_zero    = (s_tdata == BYTE_ZERO);
        v_is_start   = (s_tdata == BYTE_ONE) && (r_held >= 2'd2);
        v_z          = '0;
        v_tail       = 1'b0;
        v_run_sum    = '0;
        v_n          = '0;
        v_slot_first = 1'b0;

        n_in_unit  = r_in_unit;
        n_held     = r_held;
        n_zero_run = r_zero_run;
        n_first    = r_first;
        n_long     = r_long;

        for (int k = 0; k < MAX_RESULTS; k++) begin
            n_res[k] = '0;
        end

        if (v_is_start) begin
            // A start code closes the open unit with a bare end marker.
            if (r_in_unit) begin
                n_res[0].unit_first = r_first;
                n_res[0].long_start = r_first && r_long;
                n_res[0].unit_end   = 1'b1;
            end
            n_in_unit  = 1'b1;
            n_first    = 1'b1;
            n_long     = (r_held == HELD_MAX);
            n_held     = '0;
            n_zero_run = '0;
            v_n        = {2'b00, r_in_unit};
            // A stream that ends on a start code leaves an empty unit.
            if (s_tlast) begin
                n_res[v_n[RES_IDX_W-1:0]].unit_first = 1'b1;
                n_res[v_n[RES_IDX_W-1:0]].long_start = (r_held == HELD_MAX);
                n_res[v_n[RES_IDX_W-1:0]].unit_end   = 1'b1;
                v_n = v_n + 3'd1;
            end
        end else begin
            if (v_is_zero) begin
                if (s_tlast) begin
                    v_z = {1'b0, r_held} + 3'd1;
                end else begin
                    v_z = (r_held == HELD_MAX) ? 3'd1 : 3'd0;
                end
                n_held    = (r_held == HELD_MAX) ? HELD_MAX : r_held + 2'd1;
                v_run_sum = {1'b0, r_zero_run} + v_z;
                n_zero_run = (v_run_sum >= 3'd2) ? ZERO_RUN_MAX : v_run_sum[1:0];
            end else begin
                v_z       = {1'b0, r_held};
                v_run_sum = {1'b0, r_zero_run} + {1'b0, r_held};
                // Drop 03 after two zero payload bytes of the same unit.
                v_tail    = !(r_epb_en && (s_tdata == BYTE_EPB) && (v_run_sum >= 3'd2));
                n_held     = '0;
                n_zero_run = '0;
            end

            if (r_in_unit) begin
                v_n = v_z + {2'b00, v_tail};
                for (int k = 0; k < MAX_RESULTS; k++) begin
                    v_slot_first          = (k == 0) && r_first;
                    n_res[k].payload      = (3'(k) < v_z) ? BYTE_ZERO : s_tdata;
                    n_res[k].has_byte     = 1'b1;
                    n_res[k].unit_first   = v_slot_first;
                    n_res[k].long_start   = v_slot_first && r_long;
                    n_res[k].unit_end     = s_tlast && (3'(k) == (v_n - 3'd1));
                end
                // Nothing sent in this step: the end needs a bare marker.
                if (s_tlast && (v_n == 3'd0)) begin
                    n_res[0].payload    = BYTE_ZERO;
                    n_res[0].has_byte   = 1'b0;
                    n_res[0].unit_end   = 1'b1;
                    v_n = 3'd1;
                end
                if (v_n != 3'd0) begin
                    n_first = 1'b0;
                end
            end else begin
                n_zero_run = '0;
            end
        end

        // End of stream returns the parser to its reset state.
        if (s_tlast) begin
            n_in_unit  = 1'b0;
            n_held     = '0;
            n_zero_run = '0;
            n_first    = 1'b0;
            n_long     = 1'b0;
        end

        n_cnt = RES_CNT_W'(v_n);
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epb_en   <= 1'b1;
            r_in_unit  <= 1'b0;
            r_held     <= '0;
            r_zero_run <= '0;
            r_first    <= 1'b0;
            r_long     <= 1'b0;
            r_cnt      <= '0;
            r_idx      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_epb_en <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_in_unit  <= n_in_unit;
                r_held     <= n_held;
                r_zero_run <= n_zero_run;
                r_first    <= n_first;
                r_long     <= n_long;
                r_cnt      <= n_cnt;
                r_idx      <= '0;
            end else if (m_tvalid && m_tready) begin
                r_idx <= r_idx + RES_CNT_W'(1);
            end
        end
    end

    // Result buffer payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int k = 0; k < MAX_RESULTS; k++) begin
                r_res[k] <= n_res[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= r_cnt)
        else $error("result index ran past the loaded count");

    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready && s_tlast |=> !r_in_unit && (r_held == 2'd0) && !r_first)
        else $error("parser state not cleared after end of stream");

    a_long_needs_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser[2] |-> m_tuser[1])
        else $error("long start code flag without first flag");

    a_marker_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tuser[0] |-> m_tlast && (m_tdata == BYTE_ZERO))
        else $error("bare marker beat that does not end a unit");
`endif

endmodule
`default_nettype wire

// ===== verif/nal_beat_checker.sv =====
// ----------------------------------------------------------------------------
// nal_beat_checker
// Watches the byte stream going into the NAL unit extractor and the payload
// beats coming out. It keeps its own model of the start code and emulation
// prevention rules, queues the beats that each accepted byte must produce,
// and compares every output beat with the oldest queued one.
// ----------------------------------------------------------------------------
module nal_beat_checker
    import anxb_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_wdata,
    input  wire logic       s_tvalid,
    input  wire logic       s_tready,
    input  wire logic [7:0] s_tdata,    // [7:0] stream_byte
    input  wire logic       s_tlast,    // stream_end
    input  wire logic       m_tvalid,
    input  wire logic       m_tready,
    input  wire logic [7:0] m_tdata,    // [7:0] payload_byte
    input  wire logic [2:0] m_tuser,    // [0] has_byte, [1] unit_first, [2] long_start_code
    input  wire logic       m_tlast,    // unit_end
    output int              o_fail_count,
    output int              o_pending,
    output int              o_beats_checked,
    output int              o_units_closed
);

    localparam int MAX_PRINTED = 20;

    // Model state.
    logic       epb_enable;
    logic       in_unit;
    logic [1:0] held_zeros;
    logic [1:0] zero_run;
    logic       first_pending;
    logic       start_long;

    t_result expected_beats[$];
    t_result step_beats[$];
    t_result got;
    t_result want;

    initial begin
        o_fail_count    = 0;
        o_pending       = 0;
        o_beats_checked = 0;
        o_units_closed  = 0;
    end

    task automatic report_mismatch(input string what, input int got_val, input int want_val);
        if (o_fail_count < MAX_PRINTED)
            $display("MISMATCH at beat %0d: %s is %0h, expected %0h",
                     o_beats_checked, what, got_val, want_val);
        o_fail_count++;
    endtask

    function automatic void emit_beat(input logic has, input logic [7:0] value,
                                      input logic last);
        t_result r;
        r.payload    = has ? value : BYTE_ZERO;
        r.has_byte   = has;
        r.unit_first = first_pending;
        r.long_start = first_pending & start_long;
        r.unit_end   = last;
        first_pending = 1'b0;
        step_beats.push_back(r);
    endfunction

    // Passes one byte into the open unit, dropping an emulation prevention
    // byte that follows two zero payload bytes when removal is on.
    function automatic void forward_byte(input logic [7:0] b);
        if (!in_unit)
            return;
        if (epb_enable && zero_run == ZERO_RUN_MAX && b == BYTE_EPB) begin
            zero_run = 2'd0;
            return;
        end
        if (b == BYTE_ZERO) begin
            if (zero_run != ZERO_RUN_MAX)
                zero_run++;
        end else begin
            zero_run = 2'd0;
        end
        emit_beat(1'b1, b, 1'b0);
    endfunction

    function automatic void flush_held_zeros();
        while (held_zeros != 2'd0) begin
            forward_byte(BYTE_ZERO);
            held_zeros--;
        end
    endfunction

    task automatic predict_payload_beats(input logic [7:0] b, input logic last);
        int unit_base;
        unit_base = 0;
        step_beats.delete();
        if (b == BYTE_ZERO) begin
            if (held_zeros == HELD_MAX)
                forward_byte(BYTE_ZERO);
            else
                held_zeros++;
        end else if (b == BYTE_ONE && held_zeros >= 2'd2) begin
            if (in_unit)
                emit_beat(1'b0, BYTE_ZERO, 1'b1);
            in_unit       = 1'b1;
            first_pending = 1'b1;
            start_long    = (held_zeros == HELD_MAX);
            held_zeros    = 2'd0;
            zero_run      = 2'd0;
            unit_base     = step_beats.size();
        end else begin
            flush_held_zeros();
            forward_byte(b);
        end
        if (last) begin
            if (in_unit) begin
                flush_held_zeros();
                if (step_beats.size() > unit_base)
                    step_beats[step_beats.size() - 1].unit_end = 1'b1;
                else
                    emit_beat(1'b0, BYTE_ZERO, 1'b1);
            end
            in_unit       = 1'b0;
            held_zeros    = 2'd0;
            zero_run      = 2'd0;
            first_pending = 1'b0;
            start_long    = 1'b0;
        end
        foreach (step_beats[i])
            expected_beats.push_back(step_beats[i]);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            epb_enable    = 1'b1;
            in_unit       = 1'b0;
            held_zeros    = 2'd0;
            zero_run      = 2'd0;
            first_pending = 1'b0;
            start_long    = 1'b0;
            expected_beats.delete();
        end else begin
            // Outputs first: a byte accepted at this edge cannot have beats out yet.
            if (m_tvalid && m_tready) begin
                got.payload    = m_tdata;
                got.has_byte   = m_tuser[0];
                got.unit_first = m_tuser[1];
                got.long_start = m_tuser[2];
                got.unit_end   = m_tlast;
                if (expected_beats.size() == 0) begin
                    report_mismatch("beat with nothing expected, payload", got.payload, 0);
                end else begin
                    want = expected_beats.pop_front();
                    if (got.payload !== want.payload)
                        report_mismatch("payload_byte", got.payload, want.payload);
                    if (got.has_byte !== want.has_byte)
                        report_mismatch("has_byte", got.has_byte, want.has_byte);
                    if (got.unit_first !== want.unit_first)
                        report_mismatch("unit_first", got.unit_first, want.unit_first);
                    if (got.long_start !== want.long_start)
                        report_mismatch("long_start_code", got.long_start, want.long_start);
                    if (got.unit_end !== want.unit_end)
                        report_mismatch("unit_end", got.unit_end, want.unit_end);
                    if (want.unit_end)
                        o_units_closed++;
                end
                o_beats_checked++;
            end
            if (i_cfg_we)
                epb_enable = i_cfg_wdata;
            if (s_tvalid && s_tready)
                predict_payload_beats(s_tdata, s_tlast);
        end
        o_pending = expected_beats.size();
    end

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Top of the NAL unit extractor bench: drives Annex B byte streams with
// random gaps, stalls the payload side, switches emulation prevention removal
// on and off between phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
    import anxb_pkg::*;

    // A run of this many cycles without any beat accepted on either side means
    // the block has hung. The longest legal quiet stretch is the receiver hold.
    localparam int STALL_LIMIT  = 3000;
    localparam int RX_HOLD      = 300;
    // Cycles allowed for a byte that yields no beat to settle inside the block.
    localparam int SETTLE_WAIT  = 8;
    localparam logic STREAM_END = 1'b1;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_wdata;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [2:0] m_tuser;
    logic       m_tlast;

    int fail_count;
    int pending;
    int beats_checked;
    int units_closed;
    int bytes_sent;
    int stall_cycles;

    // Phase controls shared by the stimulus and the receiver.
    bit no_idle;
    bit rx_hold_req;

    // Each entry is {stream_end, stream_byte}.
    logic [8:0] stim_q[$];

    always #5 i_clk = ~i_clk;

    annexb_nal_unit_extractor dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    nal_beat_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_beats_checked(beats_checked),
        .o_units_closed (units_closed)
    );

    // Most gaps are short; about one in ten is a long one.
    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
    endfunction

    // Byte values are weighted toward the ones that the parser reacts to:
    // zeros build start codes, 01 closes them and 03 may be removed.
    function automatic logic [7:0] pick_byte();
        int k;
        k = $urandom_range(0, 19);
        if (k < 5)
            return BYTE_ZERO;
        else if (k < 7)
            return BYTE_ONE;
        else if (k < 9)
            return BYTE_EPB;
        return 8'($urandom_range(0, 255));
    endfunction

    // Builds one stream. Most streams are well formed: a little leading noise,
    // then units with 3-byte, 4-byte or over-long start codes and payloads that
    // often carry 00 00 03 escapes. About one in ten is pure noise. Now and then
    // the end flag lands on an arbitrary payload byte, which cuts the stream
    // short and turns what follows into leading noise of the next one.
    task automatic add_stream();
        int k;
        int plen;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 8))
                stim_q.push_back({1'b0, 8'($urandom_range(0, 255))});
        end else begin
            repeat ($urandom_range(0, 2))
                stim_q.push_back({1'b0, pick_byte()});
            repeat ($urandom_range(1, 4)) begin
                k = $urandom_range(0, 9);
                repeat ((k < 6) ? 2 : ((k < 9) ? 3 : $urandom_range(4, 6)))
                    stim_q.push_back({1'b0, BYTE_ZERO});
                stim_q.push_back({1'b0, BYTE_ONE});
                plen = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2)
                                                   : $urandom_range(3, 12);
                repeat (plen) begin
                    if ($urandom_range(0, 5) == 0) begin
                        stim_q.push_back({1'b0, BYTE_ZERO});
                        stim_q.push_back({1'b0, BYTE_ZERO});
                        stim_q.push_back({1'b0, BYTE_EPB});
                    end
                    stim_q.push_back({1'($urandom_range(0, 49) == 0), pick_byte()});
                end
            end
        end
        stim_q[stim_q.size() - 1][8] = STREAM_END;
    endtask

    // Offers one byte and holds it until the block takes it. Valid stays high
    // into the next call, so back-to-back bytes are offered with no gap in valid.
    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge i_clk);
        if (!no_idle && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat (gap_len()) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_queued(output int count);
        logic [8:0] item;
        count = 0;
        while (stim_q.size() > 0) begin
            item = stim_q.pop_front();
            send_byte(item[7:0], item[8]);
            count++;
        end
    endtask

    task automatic play_streams(input int n_items);
        int sent;
        int chunk;
        sent = 0;
        while (sent < n_items) begin
            add_stream();
            send_queued(chunk);
            sent += chunk;
        end
    endtask

    // Lowers valid and waits until every queued beat has come out, then lets the settle
    // wait pass for bytes that were absorbed without output.
    task automatic drain_block();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_WAIT) @(negedge i_clk);
    endtask

    task automatic write_epb_enable(input logic value);
        drain_block();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Receiver: random stalls, a long hold when the stimulus asks for one, and
    // a steady ready during the phases without idling.
    always begin : receiver
        int hold_left;
        @(negedge i_clk);
        if (rx_hold_req) begin
            m_tready <= 1'b0;
            rx_hold_req = 1'b0;
            for (hold_left = RX_HOLD; hold_left > 0; hold_left--)
                @(negedge i_clk);
        end else if (!no_idle && $urandom_range(0, 3) == 0) begin
            m_tready <= 1'b0;
            repeat (gap_len()) @(negedge i_clk);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog on forward progress.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int n;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'h00;
        s_tlast     = 1'b0;
        no_idle     = 1'b0;
        rx_hold_req = 1'b0;
        bytes_sent  = 0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed bytes with removal on, as after reset. In order: an end of
        // stream outside any unit; a 3-byte start code followed by 00 00 03,
        // whose 03 is dropped; a 4-byte start code that closes the unit with a
        // bare marker; a 3-byte one that leaves the long unit empty; a run of
        // four zeros whose oldest goes out as payload before a long start code;
        // a 0xFF and two held zeros flushed by the end of stream; a start code
        // whose 01 carries the end; and an escape 03 that is the unit's last byte.
        stim_q = {9'h155,
                  9'h000, 9'h000, 9'h001, 9'h000, 9'h000, 9'h003,
                  9'h000, 9'h000, 9'h000, 9'h001,
                  9'h000, 9'h000, 9'h001,
                  9'h000, 9'h000, 9'h000, 9'h000, 9'h001,
                  9'h0FF, 9'h000, 9'h100,
                  9'h000, 9'h000, 9'h101,
                  9'h000, 9'h000, 9'h001, 9'h000, 9'h000, 9'h103};
        send_queued(n);

        // With removal off the same escape must pass through untouched.
        write_epb_enable(1'b0);
        stim_q = {9'h000, 9'h000, 9'h001, 9'h000, 9'h000, 9'h103};
        send_queued(n);

        write_epb_enable(1'b1);
        play_streams(90);

        // Hold the receiver for a long stretch while bytes keep coming, so the
        // result buffer fills and the block pushes back on its input.
        rx_hold_req = 1'b1;
        play_streams(50);

        // Sender pause until every expected beat has arrived.
        drain_block();

        write_epb_enable(1'b0);
        no_idle = 1'b1;
        play_streams(70);
        no_idle = 1'b0;

        write_epb_enable(1'b1);
        play_streams(60);

        drain_block();
        repeat (12) @(negedge i_clk);

        $display("Run covered %0d stream bytes and %0d payload beats in %0d units,",
                 bytes_sent, beats_checked, units_closed);
        $display("with escape removal both on and off and a long receiver hold.");
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
